[src/kephd_pkg.sv]
`timescale 1ns / 1ps

package kephd_pkg;

  localparam int KEY_COUNT_DEF = 64;
  localparam int KEY_W = 6;
  localparam int PC_W = 7;
  localparam int TIME_W = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [1:0] REQ_REPORT = 2'd0;
  localparam logic [1:0] REQ_SCAN = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 8'd1;

  localparam logic [TIME_W-1:0] HOLD_THRESHOLD_RST = 16'd1000;
  localparam logic [TIME_W-1:0] DOUBLE_WINDOW_RST = 16'd300;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_HELD = 2'd2;

  localparam logic [1:0] DP_NONE = 2'd0;
  localparam logic [1:0] DP_ARMED = 2'd1;
  localparam logic [1:0] DP_SEEN = 2'd3;

  localparam logic [1:0] EV_PUSH = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_HOLD = 2'd2;

  localparam logic [16:0] HOLD_STEP = 17'd37;
  localparam logic [4:0] STILL_RELOAD = 5'd20;
  localparam logic [4:0] STILL_LIMIT = 5'd5;
  localparam logic [PC_W-1:0] PC_MAX = 7'd127;

  typedef struct packed {
    logic [1:0]        phase;
    logic [1:0]        dphase;
    logic [4:0]        still;
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             dbl;
    logic [KEY_W-1:0] key;
  } ev_t;

  typedef struct packed {
    logic              ev_valid;
    logic [1:0]        kind;
    logic              dbl;
    entry_t            entry;
    logic [PC_W-1:0]   pc;
    logic [TIME_W-1:0] dc;
  } upd_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_FLUSH
  } state_t;

endpackage

[src/kephd_ram.sv]
`timescale 1ns / 1ps

module kephd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/kephd_upd.sv]
`timescale 1ns / 1ps

module kephd_upd
  import kephd_pkg::*;
(
  input  logic              scan,
  input  logic              down,
  input  entry_t            entry,
  input  logic [PC_W-1:0]   pc,
  input  logic [TIME_W-1:0] dc,
  input  logic [TIME_W-1:0] hold_threshold,
  input  logic [TIME_W-1:0] double_window,
  output upd_res_t          res
);

  logic [16:0]       hold_sum;
  logic [TIME_W-1:0] hold_new;
  logic [4:0]        still_dec;
  logic [TIME_W-1:0] elapsed;
  entry_t            rel_entry;
  logic [PC_W-1:0]   rel_pc;
  logic [TIME_W-1:0] rel_dc;
  logic              rel_dbl;

  assign hold_sum = {1'b0, entry.hold} + HOLD_STEP;
  assign hold_new = hold_sum[16] ? {TIME_W{1'b1}} : hold_sum[TIME_W-1:0];
  assign still_dec = entry.still - 5'd1;
  assign elapsed = dc - entry.stamp;

  // release bookkeeping
  always_comb begin
    rel_entry = entry;
    rel_dc = dc;
    rel_dbl = 1'b0;
    if (entry.phase == PH_PRESSED) begin
      if (entry.dphase != DP_NONE && elapsed < double_window) begin
        rel_entry.dphase = DP_SEEN;
      end else begin
        if (pc == PC_W'(1)) begin
          rel_dc = '0;
        end
        rel_entry.stamp = rel_dc;
        rel_entry.dphase = DP_ARMED;
      end
    end
    rel_entry.phase = PH_IDLE;
    rel_entry.hold = '0;
    rel_entry.still = '0;
    rel_pc = (pc != '0) ? pc - PC_W'(1) : pc;
    if (rel_entry.dphase == DP_SEEN) begin
      rel_dbl = 1'b1;
      rel_entry.dphase = DP_NONE;
    end
  end

  always_comb begin
    res.ev_valid = 1'b0;
    res.kind = EV_PUSH;
    res.dbl = 1'b0;
    res.entry = entry;
    res.pc = pc;
    res.dc = dc;
    if (!scan) begin
      if (down && entry.phase == PH_IDLE) begin
        res.entry.phase = PH_PRESSED;
        res.entry.still = STILL_RELOAD;
        res.pc = (pc != PC_MAX) ? pc + PC_W'(1) : pc;
        res.ev_valid = 1'b1;
      end else if (!down && entry.phase != PH_IDLE) begin
        res.entry = rel_entry;
        res.pc = rel_pc;
        res.dc = rel_dc;
        res.ev_valid = 1'b1;
        res.kind = EV_RELEASE;
        res.dbl = rel_dbl;
      end else if (down && entry.phase == PH_PRESSED) begin
        res.entry.hold = hold_new;
        res.entry.still = STILL_RELOAD;
        if (hold_new >= hold_threshold) begin
          res.entry.phase = PH_HELD;
          res.ev_valid = 1'b1;
          res.kind = EV_HOLD;
        end
      end else if (down) begin
        res.entry.still = STILL_RELOAD;
      end
    end else if (entry.still != '0) begin
      if (still_dec <= STILL_LIMIT) begin
        res.entry = rel_entry;
        res.pc = rel_pc;
        res.dc = rel_dc;
        res.ev_valid = 1'b1;
        res.kind = EV_RELEASE;
        res.dbl = rel_dbl;
      end else begin
        res.entry.still = still_dec;
      end
    end
  end

endmodule

[src/key_event_press_hold_double.sv]
// Key report: the key entry is read from the key state RAM, updated and written back, and the result is
// registered; a new request is taken only when idle again. Timeout scan: one key entry per cycle through
// the shared update unit and the key state RAM when the output is not stalled.
// Time tick: the time counter steps on accept. Results are held one deep so the final one can carry tlast.
// Synchronous reset clears the key valid bits (all keys idle), counters, state and valid flags.
`timescale 1ns / 1ps

module key_event_press_hold_double
  import kephd_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // key_number[5:0], key_down[6], zero[7]
  input  logic [1:0]           s_axis_tuser,  // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // double_press[0], key_column[3:1], key_row[6:4], zero[7]
  output logic [1:0]           m_axis_tuser,  // event_kind
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int KW = $clog2(KEY_COUNT);
  localparam logic [KW-1:0] LAST = KW'(KEY_COUNT - 1);

  state_t            state;
  state_t            state_next;
  logic [KW-1:0]     idx;
  logic              scan_mode;
  logic              down_q;
  logic [PC_W-1:0]   pc;
  logic [TIME_W-1:0] dc;
  logic [TIME_W-1:0] hold_threshold;
  logic [TIME_W-1:0] double_window;
  logic [KEY_COUNT-1:0] valid_bits;
  logic              valid_q;
  ev_t               pend;
  logic              pend_valid;

  logic [KEY_W-1:0]  in_key;
  logic              in_down;
  logic              key_ok;
  logic              accept;
  logic              rd_en;
  logic [KW-1:0]     rd_addr;
  logic              wr_en;
  logic              commit;
  logic              stall;
  logic              more;
  logic              out_free;
  logic              load_out;
  logic              out_last;
  entry_t            ram_q;
  entry_t            entry;
  upd_res_t          res;

  assign in_key = s_axis_tdata[KEY_W-1:0];
  assign in_down = s_axis_tdata[KEY_W];
  assign key_ok = {1'b0, in_key} < 7'(KEY_COUNT);
  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign more = scan_mode && (idx != LAST);
  assign entry = valid_q ? ram_q : '0;

  kephd_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(KEY_COUNT)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(idx),
    .wr_data(res.entry),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  kephd_upd u_upd (
    .scan          (scan_mode),
    .down          (down_q),
    .entry         (entry),
    .pc            (pc),
    .dc            (dc),
    .hold_threshold(hold_threshold),
    .double_window (double_window),
    .res           (res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && ((s_axis_tuser == REQ_REPORT && key_ok) || s_axis_tuser == REQ_SCAN)) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (commit && !more) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = idx;
    wr_en = 1'b0;
    commit = 1'b0;
    stall = 1'b0;
    load_out = 1'b0;
    out_last = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && s_axis_tuser == REQ_REPORT && key_ok) begin
          rd_en = 1'b1;
          rd_addr = in_key[KW-1:0];
        end else if (accept && s_axis_tuser == REQ_SCAN) begin
          rd_en = 1'b1;
          rd_addr = '0;
        end
      end
      ST_WORK: begin
        stall = res.ev_valid && pend_valid && !out_free;
        commit = !stall;
        wr_en = commit;
        load_out = commit && res.ev_valid && pend_valid;
        if (commit && more) begin
          rd_en = 1'b1;
          rd_addr = idx + KW'(1);
        end
      end
      ST_FLUSH: begin
        load_out = pend_valid && out_free;
        out_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
      dc <= '0;
      hold_threshold <= HOLD_THRESHOLD_RST;
      double_window <= DOUBLE_WINDOW_RST;
      valid_bits <= '0;
      pend_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_index == CFG_HOLD_THRESHOLD) begin
        hold_threshold <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_DOUBLE_WINDOW) begin
        double_window <= cfg_data;
      end
      if (accept && s_axis_tuser == REQ_TICK) begin
        dc <= dc + TIME_W'(1);
      end
      if (commit) begin
        pc <= res.pc;
        dc <= res.dc;
      end
      if (wr_en) begin
        valid_bits[idx] <= 1'b1;
      end
      if (commit && res.ev_valid) begin
        pend_valid <= 1'b1;
      end else if (state == ST_FLUSH && load_out) begin
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_mode <= (s_axis_tuser == REQ_SCAN);
      down_q <= in_down;
      idx <= (s_axis_tuser == REQ_SCAN) ? '0 : in_key[KW-1:0];
    end else if (commit && more) begin
      idx <= idx + KW'(1);
    end
    if (rd_en) begin
      valid_q <= valid_bits[rd_addr];
    end
    if (commit && res.ev_valid) begin
      pend <= '{kind: res.kind, dbl: res.dbl, key: KEY_W'(idx)};
    end
    if (load_out) begin
      m_axis_tdata <= {1'b0, pend.key[2:0], pend.key[5:3], pend.dbl};
      m_axis_tuser <= pend.kind;
      m_axis_tlast <= out_last;
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("pending result left over in idle");

  a_scan_advance: assert property (@(posedge clk) disable iff (rst)
    state == ST_WORK && commit && more |=> state == ST_WORK && idx == $past(idx) + KW'(1))
    else $error("scan did not advance to next key");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_WORK && stall |=> state == ST_WORK && $stable(idx))
    else $error("key entry lost during output stall");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH && pend_valid && out_free |=> !pend_valid && m_axis_tvalid && m_axis_tlast)
    else $error("final result not marked last");

endmodule
